// ===== rtl/core/jdcc_pkg.sv =====
package jdcc_pkg;

  // field widths
  localparam int unsigned YearW   = 14;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned DayNumW = 23;
  localparam int unsigned MilW    = 20;
  localparam int unsigned SecW    = 17;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinW    = 6;

  // pipeline depth
  localparam int unsigned NumStages = 5;
  typedef logic [NumStages-1:0] stage_en_t;

  // function codes
  localparam logic FuncDateToNum = 1'b0;
  localparam logic FuncNumToDate = 1'b1;

  // date to day number: shifted year and fixed offset
  localparam int unsigned ShYearW      = 15;
  localparam int unsigned YearShift    = 8000;
  localparam int unsigned MarchMonth   = 3;
  localparam int unsigned DateSumW     = 24;
  localparam int unsigned DaysPerYear  = 365;
  // 1200820 plus the month term bias of 92 plus one for day one
  localparam int unsigned DateOffset   = 1200913;

  // floor(y / 100) and floor(y / 400) by exact reciprocal
  localparam int unsigned Q100K  = 22;
  localparam int unsigned Q100Rw = 16;
  localparam int unsigned Q100W  = 8;
  localparam longint unsigned Q100Recip = ((64'd1 << Q100K) + 64'd99) / 64'd100;
  localparam int unsigned Q400K  = 24;
  localparam int unsigned Q400Rw = 16;
  localparam int unsigned Q400W  = 6;
  localparam longint unsigned Q400Recip = ((64'd1 << Q400K) + 64'd399) / 64'd400;
  localparam int unsigned MonthTermW = 9;

  // century term: floor((4z - 7468865) / 146097), biased by 52 periods
  localparam int unsigned WNumW   = 26;
  localparam int unsigned WK      = 44;
  localparam int unsigned WRw     = 27;
  localparam int unsigned WW      = 8;
  localparam int unsigned WOffset = 128179;
  localparam longint unsigned WRecip = ((64'd1 << WK) + 64'd146096) / 64'd146097;

  // b = z + 1 + w - floor(w / 4) + 1524 with the bias folded in
  localparam int unsigned BW      = 24;
  localparam int unsigned BOffset = 1486;

  // c = floor((100b - 12210) / 36525)
  localparam int unsigned CNumW      = 30;
  localparam int unsigned CNumScale  = 100;
  localparam int unsigned CNumOffset = 12210;
  localparam int unsigned CK         = 46;
  localparam int unsigned CRw        = 31;
  localparam int unsigned CW         = 15;
  localparam longint unsigned CRecip = ((64'd1 << CK) + 64'd36524) / 64'd36525;

  // d = floor(1461c / 4), t = b - d stays within 123..488
  localparam int unsigned DProdW     = 26;
  localparam int unsigned DaysPer4Yr = 1461;
  localparam int unsigned TW         = 9;

  // e = floor(10000t / 306001)
  localparam int unsigned EK  = 28;
  localparam int unsigned ERw = 24;
  localparam int unsigned EW  = 4;
  localparam longint unsigned ERecip =
    ((64'd10000 << EK) + 64'd306000) / 64'd306001;
  localparam int unsigned ELateMonth = 13;
  localparam int unsigned YearBaseEarly = 4715;
  localparam int unsigned YearBaseLate  = 4716;

  // seconds = floor(mil * 54 / 625)
  localparam int unsigned SecK  = 30;
  localparam int unsigned SecRw = 27;
  localparam longint unsigned SecRecip = ((64'd54 << SecK) + 64'd624) / 64'd625;

  // hours = floor(s / 3600), s / 60 for the minute split
  localparam int unsigned HourK  = 29;
  localparam int unsigned HourRw = 18;
  localparam longint unsigned HourRecip = ((64'd1 << HourK) + 64'd3599) / 64'd3600;
  localparam int unsigned Min60K  = 23;
  localparam int unsigned Min60Rw = 18;
  localparam int unsigned Min60W  = 11;
  localparam longint unsigned Min60Recip = ((64'd1 << Min60K) + 64'd59) / 64'd60;
  localparam int unsigned MinPerHour = 60;

  // floor((153m + 3) / 5)
  function automatic logic [MonthTermW-1:0] month_term(input logic [MonthW-1:0] m);
    logic [MonthTermW-1:0] v;
    case (m)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd31;
      4'd2:    v = 9'd61;
      4'd3:    v = 9'd92;
      4'd4:    v = 9'd123;
      4'd5:    v = 9'd153;
      4'd6:    v = 9'd184;
      4'd7:    v = 9'd214;
      4'd8:    v = 9'd245;
      4'd9:    v = 9'd276;
      4'd10:   v = 9'd306;
      4'd11:   v = 9'd337;
      4'd12:   v = 9'd367;
      4'd13:   v = 9'd398;
      4'd14:   v = 9'd429;
      default: v = 9'd459;
    endcase
    return v;
  endfunction

  // floor(306001e / 10000)
  function automatic logic [TW-1:0] month_days(input logic [EW-1:0] e);
    logic [TW-1:0] v;
    case (e)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd30;
      4'd2:    v = 9'd61;
      4'd3:    v = 9'd91;
      4'd4:    v = 9'd122;
      4'd5:    v = 9'd153;
      4'd6:    v = 9'd183;
      4'd7:    v = 9'd214;
      4'd8:    v = 9'd244;
      4'd9:    v = 9'd275;
      4'd10:   v = 9'd306;
      4'd11:   v = 9'd336;
      4'd12:   v = 9'd367;
      4'd13:   v = 9'd397;
      4'd14:   v = 9'd428;
      default: v = 9'd459;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/jdcc_if.sv =====
// request channel
interface jdcc_req_if;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [jdcc_pkg::YearW-1:0]    year;
  logic [jdcc_pkg::MonthW-1:0]   month;
  logic [jdcc_pkg::DayW-1:0]     day;
  logic [jdcc_pkg::DayNumW-1:0]  day_number;
  logic [jdcc_pkg::MilW-1:0]     day_millionths;

  modport source (
    output valid, func, year, month, day, day_number, day_millionths,
    input  ready
  );
  modport sink (
    input  valid, func, year, month, day, day_number, day_millionths,
    output ready
  );
endinterface

// response channel
interface jdcc_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [jdcc_pkg::DayNumW-1:0]  out_day_number;
  logic [jdcc_pkg::YearW-1:0]    out_year;
  logic [jdcc_pkg::MonthW-1:0]   out_month;
  logic [jdcc_pkg::DayW-1:0]     out_day;
  logic [jdcc_pkg::SecW-1:0]     seconds_of_day;
  logic [jdcc_pkg::HourW-1:0]    hours;
  logic [jdcc_pkg::MinW-1:0]     minutes;

  modport source (
    output valid, out_day_number, out_year, out_month, out_day,
           seconds_of_day, hours, minutes,
    input  ready
  );
  modport sink (
    input  valid, out_day_number, out_year, out_month, out_day,
           seconds_of_day, hours, minutes,
    output ready
  );
endinterface

// ===== rtl/core/julian_day_calendar_converter_unit.sv =====
// Converts proleptic Gregorian dates to Julian day numbers (func 0) and day
// numbers back to year, month and day (func 1), and splits a day fraction in
// millionths into seconds, hours and minutes. One item is accepted every clock
// cycle unless the output stalls with every rank full; the depth is set by the
// day-number-to-date chain, whose three constant quotients (century term, year
// estimate, month estimate) each take a multiplier stage of their own. Each of
// the five register ranks holds while the rank after it is full and stalled,
// so a waiting result blocks input only once all five ranks hold items.
// Unused fields of a result read as zero. Inputs are not range checked.
module julian_day_calendar_converter_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  jdcc_req_if.sink          req_i,
  jdcc_rsp_if.source        rsp_o
);

  localparam int unsigned Last = jdcc_pkg::NumStages - 1;

  jdcc_pkg::stage_en_t   valid_q;
  jdcc_pkg::stage_en_t   valid_in;
  jdcc_pkg::stage_en_t   stage_rdy;
  jdcc_pkg::stage_en_t   stage_en;
  jdcc_pkg::stage_en_t   func_q;
  jdcc_pkg::stage_en_t   func_in;

  logic [jdcc_pkg::DayNumW-1:0] num_w;
  logic [jdcc_pkg::YearW-1:0]   year_w;
  logic [jdcc_pkg::MonthW-1:0]  month_w;
  logic [jdcc_pkg::DayW-1:0]    day_w;

  // stage handshake: a rank takes a new item when empty or when it drains
  assign valid_in = {valid_q[Last-1:0], req_i.valid};
  assign func_in  = {func_q[Last-1:0], req_i.func};

  always_comb begin
    stage_rdy[Last] = !valid_q[Last] || rsp_o.ready;
    for (int k = Last - 1; k >= 0; k--) begin
      stage_rdy[k] = !valid_q[k] || stage_rdy[k+1];
    end
  end

  assign stage_en    = stage_rdy & valid_in;
  assign req_i.ready = stage_rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < jdcc_pkg::NumStages; k++) begin
        if (stage_rdy[k]) begin
          valid_q[k] <= valid_in[k];
        end
      end
    end
  end

  // function code travels with its item
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < jdcc_pkg::NumStages; k++) begin
      if (stage_en[k]) begin
        func_q[k] <= func_in[k];
      end
    end
  end

  jdcc_date_path u_date (
    .clk_i        (clk_i),
    .en_i         (stage_en),
    .year_i       (req_i.year),
    .month_i      (req_i.month),
    .day_i        (req_i.day),
    .day_number_o (num_w)
  );

  jdcc_meeus_path u_meeus (
    .clk_i        (clk_i),
    .en_i         (stage_en),
    .day_number_i (req_i.day_number),
    .year_o       (year_w),
    .month_o      (month_w),
    .day_o        (day_w)
  );

  jdcc_time_split u_time (
    .clk_i            (clk_i),
    .en_i             (stage_en),
    .day_millionths_i (req_i.day_millionths),
    .seconds_o        (rsp_o.seconds_of_day),
    .hours_o          (rsp_o.hours),
    .minutes_o        (rsp_o.minutes)
  );

  // result fields of the mode not asked for read as zero
  assign rsp_o.valid          = valid_q[Last];
  assign rsp_o.out_day_number = (func_q[Last] == jdcc_pkg::FuncDateToNum) ? num_w : '0;
  assign rsp_o.out_year       = (func_q[Last] == jdcc_pkg::FuncNumToDate) ? year_w : '0;
  assign rsp_o.out_month      = (func_q[Last] == jdcc_pkg::FuncNumToDate) ? month_w : '0;
  assign rsp_o.out_day        = (func_q[Last] == jdcc_pkg::FuncNumToDate) ? day_w : '0;

  // input backs up only when every rank holds an item
  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> (&valid_q))
    else $error("input stalled with an empty rank");

  // an accepted item lands in the first rank
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> valid_q[0])
    else $error("accepted item lost at the first rank");

  // time split stays within its reachable range
  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.hours <= 5'd25 && rsp_o.minutes <= 6'd59))
    else $error("time split out of range");

  // any day number gives a real month
  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && func_q[Last] == jdcc_pkg::FuncNumToDate)
      |-> (rsp_o.out_month >= 4'd1 && rsp_o.out_month <= 4'd12))
    else $error("month out of range");

endmodule

// ===== rtl/core/jdcc_date_path.sv =====
module jdcc_date_path (
  input  logic                         clk_i,
  input  jdcc_pkg::stage_en_t          en_i,
  input  logic [jdcc_pkg::YearW-1:0]   year_i,
  input  logic [jdcc_pkg::MonthW-1:0]  month_i,
  input  logic [jdcc_pkg::DayW-1:0]    day_i,
  output logic [jdcc_pkg::DayNumW-1:0] day_number_o
);

  localparam int unsigned Q100PW = jdcc_pkg::ShYearW + jdcc_pkg::Q100Rw;
  localparam int unsigned Q400PW = jdcc_pkg::ShYearW + jdcc_pkg::Q400Rw;

  logic [jdcc_pkg::ShYearW-1:0]    y_s1;
  logic [jdcc_pkg::MonthW-1:0]     m_s1;
  logic [Q100PW-1:0]               q100_prod;
  logic [Q400PW-1:0]               q400_prod;
  logic [jdcc_pkg::DateSumW-1:0]   sum_s2;

  logic [jdcc_pkg::ShYearW-1:0]    y_q;
  logic [jdcc_pkg::Q100W-1:0]      q100_q;
  logic [jdcc_pkg::Q400W-1:0]      q400_q;
  logic [jdcc_pkg::MonthTermW-1:0] mterm_q;
  logic [jdcc_pkg::DayW-1:0]       day_q;
  logic [jdcc_pkg::DayNumW-1:0]    num_q [1:jdcc_pkg::NumStages-1];

  // january and february count as months 13 and 14 of the year before
  always_comb begin
    if (month_i < jdcc_pkg::MonthW'(jdcc_pkg::MarchMonth)) begin
      y_s1 = jdcc_pkg::ShYearW'(year_i) + jdcc_pkg::ShYearW'(jdcc_pkg::YearShift - 1);
      m_s1 = month_i + jdcc_pkg::MonthW'(12);
    end else begin
      y_s1 = jdcc_pkg::ShYearW'(year_i) + jdcc_pkg::ShYearW'(jdcc_pkg::YearShift);
      m_s1 = month_i;
    end
  end

  // century and quad-century counts by reciprocal
  assign q100_prod = Q100PW'(y_s1) * Q100PW'(jdcc_pkg::Q100Recip);
  assign q400_prod = Q400PW'(y_s1) * Q400PW'(jdcc_pkg::Q400Recip);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      y_q     <= y_s1;
      q100_q  <= q100_prod[jdcc_pkg::Q100K +: jdcc_pkg::Q100W];
      q400_q  <= q400_prod[jdcc_pkg::Q400K +: jdcc_pkg::Q400W];
      mterm_q <= jdcc_pkg::month_term(m_s1);
      day_q   <= day_i;
    end
  end

  // day count, wraps to the field width
  assign sum_s2 = jdcc_pkg::DateSumW'(y_q) * jdcc_pkg::DateSumW'(jdcc_pkg::DaysPerYear)
                + jdcc_pkg::DateSumW'(y_q >> 2)
                - jdcc_pkg::DateSumW'(q100_q)
                + jdcc_pkg::DateSumW'(q400_q)
                + jdcc_pkg::DateSumW'(mterm_q)
                + jdcc_pkg::DateSumW'(day_q)
                - jdcc_pkg::DateSumW'(jdcc_pkg::DateOffset);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      num_q[1] <= sum_s2[jdcc_pkg::DayNumW-1:0];
    end
    for (int k = 2; k < jdcc_pkg::NumStages; k++) begin
      if (en_i[k]) begin
        num_q[k] <= num_q[k-1];
      end
    end
  end

  assign day_number_o = num_q[jdcc_pkg::NumStages-1];

endmodule

// ===== rtl/core/jdcc_meeus_path.sv =====
module jdcc_meeus_path (
  input  logic                         clk_i,
  input  jdcc_pkg::stage_en_t          en_i,
  input  logic [jdcc_pkg::DayNumW-1:0] day_number_i,
  output logic [jdcc_pkg::YearW-1:0]   year_o,
  output logic [jdcc_pkg::MonthW-1:0]  month_o,
  output logic [jdcc_pkg::DayW-1:0]    day_o
);

  localparam int unsigned WPW = jdcc_pkg::WNumW + jdcc_pkg::WRw;
  localparam int unsigned CPW = jdcc_pkg::CNumW + jdcc_pkg::CRw;
  localparam int unsigned EPW = jdcc_pkg::TW + jdcc_pkg::ERw;

  logic [jdcc_pkg::WNumW-1:0]   wnum_s1;
  logic [WPW-1:0]               w_prod;
  logic [jdcc_pkg::BW-1:0]      b_s2;
  logic [jdcc_pkg::CNumW-1:0]   cnum_s2;
  logic [CPW-1:0]               c_prod;
  logic [jdcc_pkg::DProdW-1:0]  d_prod;
  logic [jdcc_pkg::BW-1:0]      t_full;
  logic [EPW-1:0]               e_prod;
  logic [jdcc_pkg::EW-1:0]      e_s5;
  logic [jdcc_pkg::TW-1:0]      day_full;
  logic [jdcc_pkg::MonthW-1:0]  month_s5;
  logic [jdcc_pkg::YearW-1:0]   year_s5;

  logic [jdcc_pkg::DayNumW-1:0] z_q;
  logic [jdcc_pkg::WW-1:0]      w_q;
  logic [jdcc_pkg::BW-1:0]      b1_q;
  logic [jdcc_pkg::CNumW-1:0]   cnum_q;
  logic [jdcc_pkg::BW-1:0]      b2_q;
  logic [jdcc_pkg::CW-1:0]      c2_q;
  logic [jdcc_pkg::CW-1:0]      c3_q;
  logic [jdcc_pkg::TW-1:0]      t_q;
  logic [jdcc_pkg::YearW-1:0]   year_q;
  logic [jdcc_pkg::MonthW-1:0]  month_q;
  logic [jdcc_pkg::DayW-1:0]    day_q;

  // century term, numerator biased positive so the quotient is a plain floor
  assign wnum_s1 = {1'b0, day_number_i, 2'b00} + jdcc_pkg::WNumW'(jdcc_pkg::WOffset);
  assign w_prod  = WPW'(wnum_s1) * WPW'(jdcc_pkg::WRecip);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      z_q <= day_number_i;
      w_q <= w_prod[jdcc_pkg::WK +: jdcc_pkg::WW];
    end
  end

  // shifted day count and numerator of the year estimate
  assign b_s2 = jdcc_pkg::BW'(z_q) + jdcc_pkg::BW'(w_q) - jdcc_pkg::BW'(w_q >> 2)
              + jdcc_pkg::BW'(jdcc_pkg::BOffset);
  assign cnum_s2 = jdcc_pkg::CNumW'(b_s2) * jdcc_pkg::CNumW'(jdcc_pkg::CNumScale)
                 - jdcc_pkg::CNumW'(jdcc_pkg::CNumOffset);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      b1_q   <= b_s2;
      cnum_q <= cnum_s2;
    end
  end

  // year estimate
  assign c_prod = CPW'(cnum_q) * CPW'(jdcc_pkg::CRecip);

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      b2_q <= b1_q;
      c2_q <= c_prod[jdcc_pkg::CK +: jdcc_pkg::CW];
    end
  end

  // days left after whole years
  assign d_prod = jdcc_pkg::DProdW'(c2_q) * jdcc_pkg::DProdW'(jdcc_pkg::DaysPer4Yr);
  assign t_full = b2_q - jdcc_pkg::BW'(d_prod >> 2);

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      t_q  <= t_full[jdcc_pkg::TW-1:0];
      c3_q <= c2_q;
    end
  end

  // month estimate, day of month and final year
  assign e_prod   = EPW'(t_q) * EPW'(jdcc_pkg::ERecip);
  assign e_s5     = e_prod[jdcc_pkg::EK +: jdcc_pkg::EW];
  assign day_full = t_q - jdcc_pkg::month_days(e_s5);

  always_comb begin
    if (e_s5 > jdcc_pkg::EW'(jdcc_pkg::ELateMonth)) begin
      month_s5 = e_s5 - jdcc_pkg::MonthW'(jdcc_pkg::ELateMonth);
    end else begin
      month_s5 = e_s5 - jdcc_pkg::MonthW'(1);
    end
    if (month_s5 == jdcc_pkg::MonthW'(1) || month_s5 == jdcc_pkg::MonthW'(2)) begin
      year_s5 = jdcc_pkg::YearW'(c3_q) - jdcc_pkg::YearW'(jdcc_pkg::YearBaseEarly);
    end else begin
      year_s5 = jdcc_pkg::YearW'(c3_q) - jdcc_pkg::YearW'(jdcc_pkg::YearBaseLate);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      year_q  <= year_s5;
      month_q <= month_s5;
      day_q   <= day_full[jdcc_pkg::DayW-1:0];
    end
  end

  assign year_o  = year_q;
  assign month_o = month_q;
  assign day_o   = day_q;

endmodule

// ===== rtl/core/jdcc_time_split.sv =====
module jdcc_time_split (
  input  logic                        clk_i,
  input  jdcc_pkg::stage_en_t         en_i,
  input  logic [jdcc_pkg::MilW-1:0]   day_millionths_i,
  output logic [jdcc_pkg::SecW-1:0]   seconds_o,
  output logic [jdcc_pkg::HourW-1:0]  hours_o,
  output logic [jdcc_pkg::MinW-1:0]   minutes_o
);

  localparam int unsigned SecPW = jdcc_pkg::MilW + jdcc_pkg::SecRw;
  localparam int unsigned HrPW  = jdcc_pkg::SecW + jdcc_pkg::HourRw;
  localparam int unsigned M60PW = jdcc_pkg::SecW + jdcc_pkg::Min60Rw;

  logic [SecPW-1:0]              sec_prod;
  logic [HrPW-1:0]               hr_prod;
  logic [M60PW-1:0]              m60_prod;
  logic [jdcc_pkg::Min60W-1:0]   min_full;

  logic [jdcc_pkg::SecW-1:0]     sec_q [0:jdcc_pkg::NumStages-1];
  logic [jdcc_pkg::HourW-1:0]    hr_q  [1:jdcc_pkg::NumStages-1];
  logic [jdcc_pkg::Min60W-1:0]   m60_q;
  logic [jdcc_pkg::MinW-1:0]     min_q [2:jdcc_pkg::NumStages-1];

  // seconds of the day
  assign sec_prod = SecPW'(day_millionths_i) * SecPW'(jdcc_pkg::SecRecip);

  // whole hours and whole minutes of the day
  assign hr_prod  = HrPW'(sec_q[0]) * HrPW'(jdcc_pkg::HourRecip);
  assign m60_prod = M60PW'(sec_q[0]) * M60PW'(jdcc_pkg::Min60Recip);

  // minutes within the hour
  assign min_full = m60_q - jdcc_pkg::Min60W'(hr_q[1]) * jdcc_pkg::Min60W'(jdcc_pkg::MinPerHour);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      sec_q[0] <= sec_prod[jdcc_pkg::SecK +: jdcc_pkg::SecW];
    end
    if (en_i[1]) begin
      sec_q[1] <= sec_q[0];
      hr_q[1]  <= hr_prod[jdcc_pkg::HourK +: jdcc_pkg::HourW];
      m60_q    <= m60_prod[jdcc_pkg::Min60K +: jdcc_pkg::Min60W];
    end
    if (en_i[2]) begin
      sec_q[2] <= sec_q[1];
      hr_q[2]  <= hr_q[1];
      min_q[2] <= min_full[jdcc_pkg::MinW-1:0];
    end
    for (int k = 3; k < jdcc_pkg::NumStages; k++) begin
      if (en_i[k]) begin
        sec_q[k] <= sec_q[k-1];
        hr_q[k]  <= hr_q[k-1];
        min_q[k] <= min_q[k-1];
      end
    end
  end

  assign seconds_o = sec_q[jdcc_pkg::NumStages-1];
  assign hours_o   = hr_q[jdcc_pkg::NumStages-1];
  assign minutes_o = min_q[jdcc_pkg::NumStages-1];

endmodule
